### sv/ftcc_pkg.sv
// ----------------------------------------------------------------------------
// Frame tick calendar clock package
// Transaction types, opcodes, calendar limits and the small arithmetic
// helpers (modulo by constants and binary to BCD) shared by the clock.
// ----------------------------------------------------------------------------
package ftcc_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_SPARE = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] set_second;
		logic [7:0] set_minute;
		logic [7:0] set_hour;
		logic [7:0] set_day;
		logic [7:0] set_month;
		logic [7:0] set_year;
	} in_t;

	typedef struct packed {
		logic [7:0] second_bcd;
		logic [7:0] minute_bcd;
		logic [7:0] hour_bcd;
		logic [7:0] day_bcd;
		logic [7:0] month_bcd;
		logic [7:0] year_bcd;
	} out_t;

	localparam logic [7:0] TPS_RESET   = 8'd60;
	localparam logic [7:0] SEC_LIMIT   = 8'd60;
	localparam logic [7:0] MIN_LIMIT   = 8'd60;
	localparam logic [7:0] HOUR_LIMIT  = 8'd24;
	localparam logic [7:0] MONTH_LIMIT = 8'd13;
	localparam logic [7:0] YEAR_LIMIT  = 8'd100;
	localparam logic [7:0] FEB_LEAP    = 8'd29;
	localparam logic [7:0] MONTH_FEB   = 8'd2;
	localparam logic [7:0] MONTH_DEC   = 8'd12;
	localparam logic [7:0] MONTH_MASK  = 8'h7F;

	localparam logic [7:0] DAYS_IN_MONTH [12] = '{
		8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
		8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
	};

	// Last valid day of the month; months outside 1..12 give zero.
	function automatic logic [7:0] day_limit(input logic [7:0] month, input logic [7:0] year);
		logic [3:0] idx;
		logic [7:0] lim;
		idx = month[3:0] - 4'd1;
		lim = 8'd0;
		if (month == MONTH_FEB && year[1:0] == 2'd0) begin
			lim = FEB_LEAP;
		end else if (month >= 8'd1 && month <= MONTH_DEC) begin
			lim = DAYS_IN_MONTH[idx];
		end
		return lim;
	endfunction

	// v mod 60 for an 8-bit value; 137/8192 overestimates 1/60 by less
	// than the smallest fractional gap over 0..255.
	function automatic logic [7:0] mod60(input logic [7:0] v);
		logic [15:0] p;
		logic [2:0]  q;
		p = 16'(v) * 16'd137;
		q = p[15:13];
		return v - 8'(8'(q) * 8'd60);
	endfunction

	// v mod 24 for an 8-bit value through the reciprocal 171/4096.
	function automatic logic [7:0] mod24(input logic [7:0] v);
		logic [15:0] p;
		logic [3:0]  q;
		p = 16'(v) * 16'd171;
		q = p[15:12];
		return v - 8'(8'(q) * 8'd24);
	endfunction

	// Tens digit in the high nibble and ones in the low nibble; tens
	// above 15 lose their upper bit, matching an 8-bit truncation.
	function automatic logic [7:0] to_bcd(input logic [7:0] v);
		logic [15:0] p;
		logic [4:0]  q;
		logic [7:0]  r;
		p = 16'(v) * 16'd205;
		q = p[15:11];
		r = v - 8'(8'(q) * 8'd10);
		return {q[3:0], r[3:0]};
	endfunction

endpackage

### sv/frame_tick_calendar_clock_unit.sv
// ----------------------------------------------------------------------------
// Frame tick calendar clock unit
// Binary calendar clock advanced by frame ticks, loaded by write
// transactions and reported as BCD bytes after every transaction.
// ----------------------------------------------------------------------------
// An accepted transaction is held in the input register and its result in
// the result register.
// Throughput: one transaction per cycle while out_stall is low; the tick
// cascade and the BCD conversion sit between the input and result registers.
// Reset: clears the clock to day 1, month 1, year 0, midnight, and sets the
// prescale to 60 ticks per second; both pipeline stages come up empty.
module frame_tick_calendar_clock_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ftcc_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ftcc_pkg::out_t   out_data,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data
);

	logic [7:0] tps_q;
	logic [7:0] tick_q, sec_q, min_q, hour_q, day_q, month_q, year_q;

	ftcc_pkg::in_t  in_s1;
	logic           valid_s1;
	ftcc_pkg::out_t out_s2;
	logic           valid_s2;
	logic           adv;

	logic [7:0] tick_inc, sec_inc, min_inc, hour_inc, day_inc, month_inc, year_inc;
	logic [7:0] lim;
	logic       c_sec, c_min, c_hour, c_day, c_month, c_year;
	logic [7:0] tick_n, sec_n, min_n, hour_n, day_n, month_n, year_n;

	assign adv       = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	// Carry cascade: each field advances only when every field below it rolls.
	always_comb begin
		tick_inc  = tick_q + 8'd1;
		sec_inc   = sec_q + 8'd1;
		min_inc   = min_q + 8'd1;
		hour_inc  = hour_q + 8'd1;
		day_inc   = day_q + 8'd1;
		month_inc = month_q + 8'd1;
		year_inc  = year_q + 8'd1;
		lim       = ftcc_pkg::day_limit(month_q, year_q);

		c_sec   = !(tick_inc < tps_q);
		c_min   = c_sec && !(sec_inc < ftcc_pkg::SEC_LIMIT);
		c_hour  = c_min && !(min_inc < ftcc_pkg::MIN_LIMIT);
		c_day   = c_hour && !(hour_inc < ftcc_pkg::HOUR_LIMIT);
		c_month = c_day && !(day_inc <= lim);
		c_year  = c_month && !(month_inc < ftcc_pkg::MONTH_LIMIT);

		tick_n  = tick_q;
		sec_n   = sec_q;
		min_n   = min_q;
		hour_n  = hour_q;
		day_n   = day_q;
		month_n = month_q;
		year_n  = year_q;

		unique case (in_s1.opcode)
			ftcc_pkg::OP_TICK: begin
				tick_n = c_sec ? 8'd0 : tick_inc;
				if (c_sec) begin
					sec_n = c_min ? 8'd0 : sec_inc;
				end
				if (c_min) begin
					min_n = c_hour ? 8'd0 : min_inc;
				end
				if (c_hour) begin
					hour_n = c_day ? 8'd0 : hour_inc;
				end
				if (c_day) begin
					day_n = c_month ? 8'd1 : day_inc;
				end
				if (c_month) begin
					month_n = c_year ? 8'd1 : month_inc;
				end
				if (c_year) begin
					year_n = (year_inc < ftcc_pkg::YEAR_LIMIT) ? year_inc : 8'd0;
				end
			end
			ftcc_pkg::OP_WRITE: begin
				sec_n   = in_s1.set_second;
				min_n   = ftcc_pkg::mod60(in_s1.set_minute);
				hour_n  = ftcc_pkg::mod24(in_s1.set_hour);
				day_n   = in_s1.set_day;
				month_n = in_s1.set_month & ftcc_pkg::MONTH_MASK;
				year_n  = in_s1.set_year;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			in_s1 <= in_data;
		end
		if (adv && valid_s1) begin
			out_s2.second_bcd <= ftcc_pkg::to_bcd(sec_n);
			out_s2.minute_bcd <= ftcc_pkg::to_bcd(min_n);
			out_s2.hour_bcd   <= ftcc_pkg::to_bcd(hour_n);
			out_s2.day_bcd    <= ftcc_pkg::to_bcd(day_n);
			out_s2.month_bcd  <= ftcc_pkg::to_bcd(month_n);
			out_s2.year_bcd   <= ftcc_pkg::to_bcd(year_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= ftcc_pkg::TPS_RESET;
			tick_q  <= 8'd0;
			sec_q   <= 8'd0;
			min_q   <= 8'd0;
			hour_q  <= 8'd0;
			day_q   <= 8'd1;
			month_q <= 8'd1;
			year_q  <= 8'd0;
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_data;
			end
			if (adv && valid_s1) begin
				tick_q  <= tick_n;
				sec_q   <= sec_n;
				min_q   <= min_n;
				hour_q  <= hour_n;
				day_q   <= day_n;
				month_q <= month_n;
				year_q  <= year_n;
			end
		end
	end

	// Minutes and hours are reduced on load and wrap on carry, so they stay in range.
	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		min_q < ftcc_pkg::MIN_LIMIT)
		else $error("minute counter out of range");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		hour_q < ftcc_pkg::HOUR_LIMIT)
		else $error("hour counter out of range");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// A held result means the transaction behind it has not yet touched the clock.
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> ($stable(sec_q) && $stable(tick_q) && $stable(day_q)))
		else $error("clock state changed while the result was stalled");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a transaction in the input register");

endmodule

### verif/frame_tick_calendar_clock_unit_checker.sv
// ----------------------------------------------------------------------------
// Frame tick calendar clock checker
// Watches the input, output and configuration ports of the clock unit and
// keeps its own copy of the calendar. Every accepted input transaction
// queues the BCD time the unit should report. Every accepted output
// transaction is compared field by field with the oldest queued time.
// ----------------------------------------------------------------------------
module frame_tick_calendar_clock_unit_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  ftcc_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_stall,
	input  ftcc_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic   [7:0]   cfg_data,
	output int             errors,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] PRESCALE_DEFAULT = 8'd60;
	localparam logic [7:0] SECONDS_WRAP     = 8'd60;
	localparam logic [7:0] MINUTES_WRAP     = 8'd60;
	localparam logic [7:0] HOURS_WRAP       = 8'd24;
	localparam logic [7:0] MONTHS_WRAP      = 8'd13;
	localparam logic [7:0] YEARS_WRAP       = 8'd100;
	localparam logic [7:0] LEAP_FEBRUARY    = 8'd29;
	localparam logic [7:0] FEBRUARY         = 8'd2;
	localparam logic [7:0] DECEMBER         = 8'd12;
	localparam logic [7:0] MONTH_BITS       = 8'h7F;
	localparam int         REPORT_LIMIT     = 10;

	localparam logic [7:0] MONTH_DAYS [12] = '{
		8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
		8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
	};

	logic [7:0] tick_prescale;
	logic [7:0] cal_ticks;
	logic [7:0] cal_second;
	logic [7:0] cal_minute;
	logic [7:0] cal_hour;
	logic [7:0] cal_day;
	logic [7:0] cal_month;
	logic [7:0] cal_year;

	ftcc_pkg::out_t expected_times [$];
	ftcc_pkg::out_t want;
	int             mismatch_count;

	function automatic logic [7:0] bcd_of(input logic [7:0] v);
		int unsigned t;
		t = v;
		return 8'((t / 10) * 16 + t % 10);
	endfunction

	// Months outside 1..12 have no valid day, so the next day carries.
	function automatic logic [7:0] month_length(input logic [7:0] m, input logic [7:0] y);
		if (m == FEBRUARY && y % 4 == 0) begin
			return LEAP_FEBRUARY;
		end
		if (m >= 8'd1 && m <= DECEMBER) begin
			return MONTH_DAYS[4'(m - 8'd1)];
		end
		return 8'd0;
	endfunction

	// Every counter wraps at 8 bits; a wrapped value under its limit ends the carry.
	function void advance_calendar();
		cal_ticks = cal_ticks + 8'd1;
		if (cal_ticks < tick_prescale) return;
		cal_ticks = 8'd0;
		cal_second = cal_second + 8'd1;
		if (cal_second < SECONDS_WRAP) return;
		cal_second = 8'd0;
		cal_minute = cal_minute + 8'd1;
		if (cal_minute < MINUTES_WRAP) return;
		cal_minute = 8'd0;
		cal_hour = cal_hour + 8'd1;
		if (cal_hour < HOURS_WRAP) return;
		cal_hour = 8'd0;
		cal_day = cal_day + 8'd1;
		if (cal_day <= month_length(cal_month, cal_year)) return;
		cal_day = 8'd1;
		cal_month = cal_month + 8'd1;
		if (cal_month < MONTHS_WRAP) return;
		cal_month = 8'd1;
		cal_year = cal_year + 8'd1;
		if (cal_year < YEARS_WRAP) return;
		cal_year = 8'd0;
	endfunction

	function void apply_transaction(input ftcc_pkg::in_t item);
		case (item.opcode)
			ftcc_pkg::OP_TICK: begin
				advance_calendar();
			end
			ftcc_pkg::OP_WRITE: begin
				cal_second = item.set_second;
				cal_minute = item.set_minute % MINUTES_WRAP;
				cal_hour   = item.set_hour % HOURS_WRAP;
				cal_day    = item.set_day;
				cal_month  = item.set_month & MONTH_BITS;
				cal_year   = item.set_year;
			end
			default: begin
			end
		endcase
		expected_times.push_back('{
			second_bcd: bcd_of(cal_second),
			minute_bcd: bcd_of(cal_minute),
			hour_bcd:   bcd_of(cal_hour),
			day_bcd:    bcd_of(cal_day),
			month_bcd:  bcd_of(cal_month),
			year_bcd:   bcd_of(cal_year)
		});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_prescale = PRESCALE_DEFAULT;
			cal_ticks = 8'd0;
			cal_second = 8'd0;
			cal_minute = 8'd0;
			cal_hour = 8'd0;
			cal_day = 8'd1;
			cal_month = 8'd1;
			cal_year = 8'd0;
			expected_times.delete();
			mismatch_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				tick_prescale = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_times.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%0t: unexpected result %h", $realtime, out_data);
					end
				end else begin
					want = expected_times.pop_front();
					if (out_data.second_bcd !== want.second_bcd ||
						out_data.minute_bcd !== want.minute_bcd ||
						out_data.hour_bcd !== want.hour_bcd ||
						out_data.day_bcd !== want.day_bcd ||
						out_data.month_bcd !== want.month_bcd ||
						out_data.year_bcd !== want.year_bcd) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display({"%0t: time mismatch, expected %h:%h:%h %h/%h/%h,",
								" got %h:%h:%h %h/%h/%h"},
								$realtime,
								want.hour_bcd, want.minute_bcd, want.second_bcd,
								want.day_bcd, want.month_bcd, want.year_bcd,
								out_data.hour_bcd, out_data.minute_bcd,
								out_data.second_bcd, out_data.day_bcd,
								out_data.month_bcd, out_data.year_bcd);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				apply_transaction(in_data);
			end
			errors <= mismatch_count;
			pending <= expected_times.size();
		end
	end

endmodule

### verif/frame_tick_calendar_clock_unit_test.sv
// ----------------------------------------------------------------------------
// Frame tick calendar clock unit test
// Drives directed calendar rollovers and then randomized tick, read, spare and
// write transactions under several prescale settings, with random idle
// bursts on both sides and one long output hold. A checker beside the
// unit predicts every reported time and counts mismatches.
// ----------------------------------------------------------------------------
module frame_tick_calendar_clock_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT     = 300000;
	localparam int HOLD_CYCLES     = 400;
	localparam int PHASE_COUNT     = 6;
	localparam int PHASE_ITEMS     = 250;
	localparam int DRAIN_CYCLES    = 20;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	ftcc_pkg::in_t  in_data;
	logic out_valid;
	logic out_stall;
	ftcc_pkg::out_t out_data;
	logic cfg_we;
	logic [7:0] cfg_data;

	int errors;
	int pending;
	int cycles;
	bit idle_off;
	bit hold_output;

	logic [7:0] phase_prescale [PHASE_COUNT] = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd60, 8'd3};

	frame_tick_calendar_clock_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	frame_tick_calendar_clock_unit_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("frame_tick_calendar_clock_unit regression: fail");
		$finish;
	end

	function automatic ftcc_pkg::in_t make_write(input logic [7:0] s, input logic [7:0] m,
		input logic [7:0] h, input logic [7:0] d, input logic [7:0] mo, input logic [7:0] y);
		ftcc_pkg::in_t t;
		t.opcode = ftcc_pkg::OP_WRITE;
		t.set_second = s;
		t.set_minute = m;
		t.set_hour = h;
		t.set_day = d;
		t.set_month = mo;
		t.set_year = y;
		return t;
	endfunction

	// Payload bytes are random; only a write looks at them.
	function automatic ftcc_pkg::in_t make_op(input ftcc_pkg::opcode_t op);
		ftcc_pkg::in_t t;
		t = make_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		t.opcode = op;
		return t;
	endfunction

	// Mostly ticks, with writes that often land just before a rollover.
	function automatic ftcc_pkg::in_t random_transaction();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 12) return make_op(ftcc_pkg::OP_TICK);
		if (pick < 14) return make_op(ftcc_pkg::OP_READ);
		if (pick < 15) return make_op(ftcc_pkg::OP_SPARE);
		if (pick < 17) return make_op(ftcc_pkg::OP_WRITE);
		return make_write(8'($urandom_range(57, 59)),
			$urandom_range(0, 1) ? 8'd59 : 8'd119,
			$urandom_range(0, 1) ? 8'd23 : 8'd47, 8'($urandom_range(27, 31)),
			8'($urandom_range(0, 14)),
			$urandom_range(0, 1) ? 8'($urandom_range(96, 103)) : 8'($urandom_range(0, 7)));
	endfunction

	task automatic send_transaction(input ftcc_pkg::in_t item);
		if (!idle_off && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// The first edge lets the checker count a transaction accepted just now.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_prescale(input logic [7:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else if (!idle_off && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	initial begin
		idle_off = 1'b0;
		hold_output = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_data <= 8'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rollovers with one tick per second.
		load_prescale(8'd1);
		send_transaction(make_op(ftcc_pkg::OP_READ));
		send_transaction(make_op(ftcc_pkg::OP_SPARE));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		send_transaction(make_write(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		send_transaction(make_write(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		send_transaction(make_write(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd99));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		send_transaction(make_write(8'd59, 8'd59, 8'd23, 8'd28, 8'd2, 8'd4));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		send_transaction(make_write(8'd59, 8'd59, 8'd23, 8'd29, 8'd2, 8'd4));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		send_transaction(make_write(8'd59, 8'd59, 8'd23, 8'd28, 8'd2, 8'd1));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		// Month thirteen has no valid day and carries into the year.
		send_transaction(make_write(8'd59, 8'd59, 8'd23, 8'd5, 8'd13, 8'd7));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		send_transaction(make_write(8'd59, 8'd59, 8'd23, 8'd0, 8'd0, 8'd7));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		send_transaction(make_write(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd200));
		send_transaction(make_op(ftcc_pkg::OP_TICK));
		// A day of 255 wraps to 0, which stops the carry even in a bad month.
		send_transaction(make_write(8'd59, 8'd59, 8'd23, 8'd255, 8'd127, 8'd50));
		send_transaction(make_op(ftcc_pkg::OP_TICK));

		for (int p = 0; p < PHASE_COUNT; p++) begin
			load_prescale(phase_prescale[p]);
			if (p == 1) begin
				hold_output = 1'b1;
			end
			if (p == PHASE_COUNT - 1) begin
				idle_off = 1'b1;
			end
			repeat (PHASE_ITEMS) send_transaction(random_transaction());
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("frame_tick_calendar_clock_unit regression: pass");
		end else begin
			$display("frame_tick_calendar_clock_unit regression: fail");
		end
		$finish;
	end

endmodule
